FILE: hdl/battery_self_consumption_dispatch_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the battery dispatch unit
// Compile with NO_ASSERTIONS defined to leave every check out.
// ----------------------------------------------------------------------------
`ifndef BATTERY_SELF_CONSUMPTION_DISPATCH_UNIT_MACROS_SVH
`define BATTERY_SELF_CONSUMPTION_DISPATCH_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check that the consequent holds in the same cycle as the antecedent
`define BSC_CHECK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Check that the consequent holds in the cycle after the antecedent
`define BSC_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BSC_CHECK_NOW(label, ante, cons, msg)
`define BSC_CHECK_NEXT(label, ante, cons, msg)
`endif

`endif

FILE: hdl/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg
// Types and constants shared by the battery dispatch unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bsc_pkg;

    // Configuration register widths
    localparam int CAP_W = 32;
    localparam int EFF_W = 17;
    localparam int INV_W = 18;
    localparam int THR_W = 24;
    localparam int CFG_W = 32;
    localparam int IDX_W = 2;

    // Accumulator widths
    localparam int TOT_W = 48;
    localparam int CNT_W = 9;

    // Register indexes of the configuration port
    localparam logic [IDX_W-1:0] CFG_CAPACITY   = 2'd0;
    localparam logic [IDX_W-1:0] CFG_EFFICIENCY = 2'd1;
    localparam logic [IDX_W-1:0] CFG_INVERSE    = 2'd2;
    localparam logic [IDX_W-1:0] CFG_THRESHOLD  = 2'd3;

    // Reset values of the configuration registers
    localparam logic [CAP_W-1:0] CAP_RESET = 32'd0;
    localparam logic [EFF_W-1:0] EFF_RESET = 17'd63570;
    localparam logic [INV_W-1:0] INV_RESET = 18'd67563;
    localparam logic [THR_W-1:0] THR_RESET = 24'd50000;

    // Unity in Q1.16 and the number of fraction bits for a 16-bit shift
    localparam logic [EFF_W-1:0] Q_ONE     = 17'd65536;
    localparam int               FRAC_BITS = 16;

    // Saturation limits
    localparam logic [CNT_W-1:0] CNT_MAX = 9'd511;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL1,
        ST_CLAMP,
        ST_MUL2,
        ST_SETTLE,
        ST_TOTAL
    } state_t;

    // Saturating add for the year totals
    function automatic logic [TOT_W-1:0] sat_add(input logic [TOT_W-1:0] a,
                                                 input logic [TOT_W-1:0] b);
        logic [TOT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TOT_W] ? {TOT_W{1'b1}} : s[TOT_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: hdl/bsc_mul.sv
// ----------------------------------------------------------------------------
// bsc_mul
// Shared registered multiplier of the dispatch sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module bsc_mul
    import bsc_pkg::*;
#(
    parameter int A_W = 24,
    parameter int B_W = 18
)
(
    input  wire logic               clk,
    input  wire logic               load,
    input  wire logic [A_W-1:0]     a,
    input  wire logic [B_W-1:0]     b,
    output logic      [A_W+B_W-1:0] p
);

    logic [A_W+B_W-1:0] p_reg;

    // Capture the product when the sequencer asks for it
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            p_reg <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

FILE: hdl/battery_self_consumption_dispatch_unit.sv
// ----------------------------------------------------------------------------
// Battery self-consumption dispatch unit
// Steps: a charging slot goes through prep, multiply, clamp, multiply, settle
// and total, so the shared multiplier runs twice; any other slot or a restart
// item goes from prep to settle and total. A new item is taken only in idle,
// after the total step, which waits while a previous result is held.
// Reset clears the charge, day sum and totals and loads default registers.
// ----------------------------------------------------------------------------
`default_nettype none

`include "battery_self_consumption_dispatch_unit_macros.svh"

module battery_self_consumption_dispatch_unit
    import bsc_pkg::*;
#(
    parameter int ENERGY_BITS = 24
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   cfg_write,
    input  wire logic [IDX_W-1:0]       cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data,

    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   kind,
    input  wire logic [ENERGY_BITS-1:0] pv_energy,
    input  wire logic [ENERGY_BITS-1:0] load_energy,
    input  wire logic                   last_of_day,
    input  wire logic                   last_of_year,

    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [ENERGY_BITS-1:0]      self_consumed,
    output logic [ENERGY_BITS-1:0]      exported,
    output logic [ENERGY_BITS-1:0]      imported,
    output logic [CAP_W-1:0]            charge_level,
    output logic                        day_deficit,
    output logic [CNT_W-1:0]            deficit_day_count,
    output logic [TOT_W-1:0]            year_pv,
    output logic [TOT_W-1:0]            year_load,
    output logic [TOT_W-1:0]            year_self,
    output logic [TOT_W-1:0]            year_export,
    output logic [TOT_W-1:0]            year_import
);

    localparam int EB    = ENERGY_BITS;
    localparam int EB1   = EB + 1;
    localparam int PRD_W = EB + INV_W;
    localparam int RND_W = PRD_W + 1;
    localparam int USE_W = RND_W - FRAC_BITS;
    localparam logic [RND_W-1:0] ROUND_HALF = RND_W'(1) << (FRAC_BITS - 1);

    // Sequencer
    state_t state_reg;
    state_t state_next;

    // Configuration registers
    logic [CAP_W-1:0] cap_reg;
    logic [EFF_W-1:0] eff_reg;
    logic [INV_W-1:0] inv_reg;
    logic [THR_W-1:0] thr_reg;

    // Captured item
    logic          kind_reg;
    logic [EB-1:0] pv_reg;
    logic [EB-1:0] load_reg;
    logic          lod_reg;
    logic          loy_reg;

    // Working values
    logic [EB-1:0]    diff_reg;
    logic             pv_ge_reg;
    logic [CAP_W-1:0] room_reg;
    logic [EFF_W-1:0] effc_reg;
    logic [EB-1:0]    chg_reg;
    logic             fit_reg;
    logic [EB-1:0]    self_reg;
    logic [EB-1:0]    exp_reg;
    logic [EB-1:0]    imp_reg;

    // Block state
    logic [CAP_W-1:0] stored_reg;
    logic [CAP_W-1:0] day_sum_reg;
    logic [CNT_W-1:0] days_reg;
    logic [TOT_W-1:0] pv_tot_reg;
    logic [TOT_W-1:0] load_tot_reg;
    logic [TOT_W-1:0] self_tot_reg;
    logic [TOT_W-1:0] exp_tot_reg;
    logic [TOT_W-1:0] imp_tot_reg;

    // Result registers
    logic             out_valid_reg;
    logic [EB-1:0]    self_out_reg;
    logic [EB-1:0]    exp_out_reg;
    logic [EB-1:0]    imp_out_reg;
    logic [CAP_W-1:0] charge_out_reg;
    logic             deficit_out_reg;
    logic [CNT_W-1:0] days_out_reg;
    logic [TOT_W-1:0] pv_out_reg;
    logic [TOT_W-1:0] load_out_reg;
    logic [TOT_W-1:0] self_out_tot_reg;
    logic [TOT_W-1:0] exp_out_tot_reg;
    logic [TOT_W-1:0] imp_out_tot_reg;

    // Sequencer outputs
    logic accept;
    logic mul_load;
    logic out_free;
    logic total_fire;

    // Shared multiplier
    logic [EB-1:0]    mul_a;
    logic [INV_W-1:0] mul_b;
    logic [PRD_W-1:0] mul_p;

    // Combinational datapath
    logic             pv_ge;
    logic [EB-1:0]    want;
    logic [RND_W-1:0] rnd;
    logic [USE_W-1:0] used_raw;
    logic [EB-1:0]    used;
    logic [EB-1:0]    from_batt;
    logic [EB-1:0]    self_next;
    logic [EB-1:0]    exp_next;
    logic [EB-1:0]    imp_next;
    logic [CAP_W-1:0] stored_next;
    logic [CAP_W:0]   day_add;
    logic [CAP_W-1:0] day_sum_next;
    logic             deficit_next;
    logic [CNT_W-1:0] days_next;
    logic [TOT_W-1:0] pv_tot_next;
    logic [TOT_W-1:0] load_tot_next;
    logic [TOT_W-1:0] self_tot_next;
    logic [TOT_W-1:0] exp_tot_next;
    logic [TOT_W-1:0] imp_tot_next;
    logic [EB1-1:0]   bal_sum;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
            eff_reg <= EFF_RESET;
            inv_reg <= INV_RESET;
            thr_reg <= THR_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_CAPACITY:   cap_reg <= cfg_data[CAP_W-1:0];
                CFG_EFFICIENCY: eff_reg <= cfg_data[EFF_W-1:0];
                CFG_INVERSE:    inv_reg <= cfg_data[INV_W-1:0];
                CFG_THRESHOLD:  thr_reg <= cfg_data[THR_W-1:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    assign pv_ge    = (pv_reg >= load_reg);
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                if (kind_reg || (cap_reg == '0) || !pv_ge)
                begin
                    state_next = ST_SETTLE;
                end
                else
                begin
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:   state_next = ST_CLAMP;
            ST_CLAMP:  state_next = ST_MUL2;
            ST_MUL2:   state_next = ST_SETTLE;
            ST_SETTLE: state_next = ST_TOTAL;
            ST_TOTAL:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        in_ready   = 1'b0;
        mul_load   = 1'b0;
        total_fire = 1'b0;
        unique case (state_reg)
            ST_IDLE:  in_ready   = 1'b1;
            ST_MUL1:  mul_load   = 1'b1;
            ST_MUL2:  mul_load   = 1'b1;
            ST_TOTAL: total_fire = out_free;
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Capture the item
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind;
            pv_reg   <= pv_energy;
            load_reg <= load_energy;
            lod_reg  <= last_of_day;
            loy_reg  <= last_of_year;
        end
    end

    // ------------------------------------------------------------------
    // Balance, room and clamped efficiency
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_PREP)
        begin
            pv_ge_reg <= pv_ge;
            diff_reg  <= pv_ge ? (pv_reg - load_reg) : (load_reg - pv_reg);
            room_reg  <= (cap_reg > stored_reg) ? (cap_reg - stored_reg) : '0;
            effc_reg  <= (eff_reg > Q_ONE) ? Q_ONE : eff_reg;
        end
    end

    // ------------------------------------------------------------------
    // Shared multiplier: surplus times efficiency, then charge times inverse
    // ------------------------------------------------------------------
    assign mul_a = (state_reg == ST_MUL1) ? diff_reg : chg_reg;
    assign mul_b = (state_reg == ST_MUL1) ? {1'b0, effc_reg} : inv_reg;

    bsc_mul #(
        .A_W (EB),
        .B_W (INV_W)
    ) u_mul (
        .clk  (clk),
        .load (mul_load),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    // Limit the charge to the room left in the battery
    assign want = mul_p[FRAC_BITS +: EB];

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLAMP)
        begin
            if (CAP_W'(want) <= room_reg)
            begin
                chg_reg <= want;
                fit_reg <= (effc_reg != '0);
            end
            else
            begin
                chg_reg <= room_reg[EB-1:0];
                fit_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Settle the slot energies and the charge
    // ------------------------------------------------------------------
    assign rnd      = RND_W'(mul_p) + ROUND_HALF;
    assign used_raw = rnd[RND_W-1:FRAC_BITS];

    always_comb
    begin
        if (fit_reg || (used_raw > USE_W'(diff_reg)))
        begin
            used = diff_reg;
        end
        else
        begin
            used = used_raw[EB-1:0];
        end
    end

    assign from_batt = (CAP_W'(diff_reg) < stored_reg) ? diff_reg : stored_reg[EB-1:0];

    always_comb
    begin
        self_next   = '0;
        exp_next    = '0;
        imp_next    = '0;
        stored_next = stored_reg;
        if (kind_reg)
        begin
            stored_next = cap_reg >> 1;
        end
        else if (cap_reg == '0)
        begin
            // No battery: solar feeds the load directly
            if (pv_ge_reg)
            begin
                self_next = load_reg;
                exp_next  = diff_reg;
            end
            else
            begin
                self_next = pv_reg;
                imp_next  = diff_reg;
            end
        end
        else if (pv_ge_reg)
        begin
            self_next   = load_reg;
            exp_next    = diff_reg - used;
            stored_next = stored_reg + CAP_W'(chg_reg);
        end
        else
        begin
            // Draw on the battery first, then on the grid
            self_next   = pv_reg + from_batt;
            imp_next    = diff_reg - from_batt;
            stored_next = stored_reg - CAP_W'(from_batt);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SETTLE)
        begin
            self_reg <= self_next;
            exp_reg  <= exp_next;
            imp_reg  <= imp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_reg <= '0;
        end
        else if (state_reg == ST_SETTLE)
        begin
            stored_reg <= stored_next;
        end
    end

    // ------------------------------------------------------------------
    // Day sum, deficit days and year totals
    // ------------------------------------------------------------------
    assign day_add      = {1'b0, day_sum_reg} + (CAP_W+1)'(imp_reg);
    assign day_sum_next = day_add[CAP_W] ? {CAP_W{1'b1}} : day_add[CAP_W-1:0];
    assign deficit_next = lod_reg && (day_sum_next > CAP_W'(thr_reg));
    assign days_next    = (deficit_next && (days_reg != CNT_MAX)) ? days_reg + 1'b1
                                                                  : days_reg;

    assign pv_tot_next   = sat_add(pv_tot_reg,   TOT_W'(pv_reg));
    assign load_tot_next = sat_add(load_tot_reg, TOT_W'(load_reg));
    assign self_tot_next = sat_add(self_tot_reg, TOT_W'(self_reg));
    assign exp_tot_next  = sat_add(exp_tot_reg,  TOT_W'(exp_reg));
    assign imp_tot_next  = sat_add(imp_tot_reg,  TOT_W'(imp_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            day_sum_reg  <= '0;
            days_reg     <= '0;
            pv_tot_reg   <= '0;
            load_tot_reg <= '0;
            self_tot_reg <= '0;
            exp_tot_reg  <= '0;
            imp_tot_reg  <= '0;
        end
        else if (total_fire)
        begin
            if (kind_reg || loy_reg)
            begin
                days_reg     <= '0;
                pv_tot_reg   <= '0;
                load_tot_reg <= '0;
                self_tot_reg <= '0;
                exp_tot_reg  <= '0;
                imp_tot_reg  <= '0;
            end
            else
            begin
                days_reg     <= days_next;
                pv_tot_reg   <= pv_tot_next;
                load_tot_reg <= load_tot_next;
                self_tot_reg <= self_tot_next;
                exp_tot_reg  <= exp_tot_next;
                imp_tot_reg  <= imp_tot_next;
            end
            // Drop the day sum on a restart or at the end of a day
            if (kind_reg || lod_reg)
            begin
                day_sum_reg <= '0;
            end
            else
            begin
                day_sum_reg <= day_sum_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (total_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (total_fire)
        begin
            self_out_reg   <= self_reg;
            exp_out_reg    <= exp_reg;
            imp_out_reg    <= imp_reg;
            charge_out_reg <= stored_reg;
            if (kind_reg)
            begin
                deficit_out_reg  <= 1'b0;
                days_out_reg     <= '0;
                pv_out_reg       <= '0;
                load_out_reg     <= '0;
                self_out_tot_reg <= '0;
                exp_out_tot_reg  <= '0;
                imp_out_tot_reg  <= '0;
            end
            else
            begin
                deficit_out_reg  <= deficit_next;
                days_out_reg     <= days_next;
                pv_out_reg       <= pv_tot_next;
                load_out_reg     <= load_tot_next;
                self_out_tot_reg <= self_tot_next;
                exp_out_tot_reg  <= exp_tot_next;
                imp_out_tot_reg  <= imp_tot_next;
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign self_consumed     = self_out_reg;
    assign exported          = exp_out_reg;
    assign imported          = imp_out_reg;
    assign charge_level      = charge_out_reg;
    assign day_deficit       = deficit_out_reg;
    assign deficit_day_count = days_out_reg;
    assign year_pv           = pv_out_reg;
    assign year_load         = load_out_reg;
    assign year_self         = self_out_tot_reg;
    assign year_export       = exp_out_tot_reg;
    assign year_import       = imp_out_tot_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    assign bal_sum = EB1'(self_reg) + EB1'(imp_reg);

    `BSC_CHECK_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "item taken while busy")
    `BSC_CHECK_NOW(a_load_balance, (state_reg == ST_TOTAL) && !kind_reg, bal_sum == EB1'(load_reg), "self plus import differs from load")
    `BSC_CHECK_NOW(a_result_source, $rose(out_valid_reg), $past(state_reg) == ST_TOTAL, "result raised outside the total step")
    `BSC_CHECK_NEXT(a_charge_bound, (state_reg == ST_CLAMP), CAP_W'(chg_reg) <= room_reg, "charge exceeds room")

endmodule

`default_nettype wire
